FILE: src/i2c_target_command_mailbox_macros.svh
// Assertion macros shared by the mailbox RTL.
`ifndef I2C_TARGET_COMMAND_MAILBOX_MACROS_SVH
`define I2C_TARGET_COMMAND_MAILBOX_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ITCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ITCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/itcm_pkg.sv
// Types, codes and constants for the I2C target command mailbox.
`default_nettype none

package itcm_pkg;

  localparam int MODE_W = 4;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 6;

  localparam int RX_DEPTH_DEF = 32;
  localparam int TX_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  localparam logic [MODE_W-1:0] MODE_ADDR_WRITE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_MASTER_BYTE = 4'd1;
  localparam logic [MODE_W-1:0] MODE_READ_REQ   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_READ_DONE  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TX_LOAD    = 4'd4;
  localparam logic [MODE_W-1:0] MODE_TX_LENGTH  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_TX_REWIND  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_TAKE_CMD   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RX_READ    = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADDR_MATCH,
    OP_WRITE_BYTE,
    OP_READ_REQ,
    OP_TX_LOAD,
    OP_TX_LENGTH,
    OP_TX_REWIND,
    OP_TAKE_CMD,
    OP_RX_READ
  } op_t;

  typedef enum logic {
    BK_EXEC,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  index;
    logic [LEN_W-1:0]  length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              command_pending;
    logic [CNT_W-1:0]  rx_count;
    logic [CNT_W-1:0]  tx_position;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  index;
    logic [LEN_W-1:0]  length;
  } op_item_t;

endpackage

`default_nettype wire

FILE: src/i2c_target_command_mailbox.sv
// Top level of the I2C target command mailbox.
//
// Input channel: a queue write port (push, full, in_item). Each transfer is one
// decoded bus event or host access; it is taken when push is high and full low.
// Result channel: a queue read port (empty, pop, out_item). Every input transfer
// yields exactly one result, in order, holding the byte served and the pending
// flag, receive count and transmit position after that operation.
// Decoded operations wait in a two-entry queue ahead of the executing back end,
// and one output register holds the finished result.
// A master read request or receive read that hits a buffer entry passes through the
// registered buffer RAM read and the read state before its result is loaded.
// Throughput: one operation per cycle while the output register is free or popped;
// a buffer read holds off the next operation until its result is loaded.
// Reset clears the command, pending flag, counts and pointers; buffer contents
// stay as they were. While pop is held low the output register keeps its
// result, the queue fills, and full rises after two more transfers.
`default_nettype none

module i2c_target_command_mailbox #(
  parameter int RX_DEPTH = itcm_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = itcm_pkg::TX_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire itcm_pkg::in_item_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output itcm_pkg::out_item_t      out_item
);

  import itcm_pkg::*;

  logic     q_valid;
  logic     q_pop;
  op_item_t q_item;

  itcm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  itcm_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: src/itcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/itcm_front.sv
// Front end: accept input transfers, decode the mode and queue the operation.
`default_nettype none

`include "i2c_target_command_mailbox_macros.svh"

module itcm_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire itcm_pkg::in_item_t in_item,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output itcm_pkg::op_item_t      q_item
);

  import itcm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_item_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  op_item_t        dec_item;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    dec_item.data_byte = in_item.data_byte;
    dec_item.index     = in_item.index;
    dec_item.length    = in_item.length;
    unique case (in_item.mode)
      MODE_ADDR_WRITE:  dec_item.op = OP_ADDR_MATCH;
      MODE_MASTER_BYTE: dec_item.op = OP_WRITE_BYTE;
      MODE_READ_REQ:    dec_item.op = OP_READ_REQ;
      MODE_TX_LOAD:     dec_item.op = OP_TX_LOAD;
      MODE_TX_LENGTH:   dec_item.op = OP_TX_LENGTH;
      MODE_TX_REWIND:   dec_item.op = OP_TX_REWIND;
      MODE_TAKE_CMD:    dec_item.op = OP_TAKE_CMD;
      MODE_RX_READ:     dec_item.op = OP_RX_READ;
      default:          dec_item.op = OP_NOP;
    endcase
  end

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= dec_item;
    end
  end

  `ITCM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(QUEUE_DEPTH), "queue count overflow")
  `ITCM_ASSERT_NEXT(a_push_counts, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + CW'(1), "push lost")
  `ITCM_ASSERT_NEXT(a_pop_counts, clk, rst_n, do_pop && !do_push, count_r == $past(count_r) - CW'(1), "pop lost")

endmodule

`default_nettype wire

FILE: src/itcm_back.sv
// Back end: execute queued operations against mailbox state and buffers.
`default_nettype none

`include "i2c_target_command_mailbox_macros.svh"

module itcm_back #(
  parameter int RX_DEPTH = itcm_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = itcm_pkg::TX_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire itcm_pkg::op_item_t q_item,
  output logic                    empty,
  input  wire logic               pop,
  output itcm_pkg::out_item_t     out_item
);

  import itcm_pkg::*;

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int RX_KW = RX_CW + IDX_W;
  localparam int TX_KW = TX_CW + IDX_W;
  localparam int TL_KW = TX_CW + LEN_W;

  bk_state_t          state_r, state_nxt;
  logic [BYTE_W-1:0]  cmd_r, cmd_nxt;
  logic               pending_r, pending_nxt;
  logic               expect_r, expect_nxt;
  logic [RX_CW-1:0]   rx_fill_r, rx_fill_nxt;
  logic [TX_CW-1:0]   tx_limit_r, tx_limit_nxt;
  logic [TX_CW-1:0]   tx_ptr_r, tx_ptr_nxt;
  logic               rd_rx_r, rd_rx_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               out_pop;
  logic               can_out;
  logic               out_load;
  logic [BYTE_W-1:0]  res_byte;

  logic               rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0]  rx_rdata, tx_rdata;
  logic [RX_KW-1:0]   idx_rx_k, fill_k;
  logic [TX_KW-1:0]   idx_tx_k;
  logic [TL_KW-1:0]   len_k;
  logic [RX_AW-1:0]   rx_rd_addr;
  logic [TX_AW-1:0]   tx_wr_addr;
  logic [RX_CW+CNT_W-1:0] rx_cnt_k;
  logic [TX_CW+CNT_W-1:0] tx_cnt_k;

  assign idx_rx_k   = {{RX_CW{1'b0}}, q_item.index};
  assign fill_k     = {{IDX_W{1'b0}}, rx_fill_r};
  assign idx_tx_k   = {{TX_CW{1'b0}}, q_item.index};
  assign len_k      = {{TX_CW{1'b0}}, q_item.length};
  assign rx_rd_addr = idx_rx_k[RX_AW-1:0];
  assign tx_wr_addr = idx_tx_k[TX_AW-1:0];

  assign out_pop = pop && out_valid_r;
  assign can_out = !out_valid_r || out_pop;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    pending_nxt  = pending_r;
    expect_nxt   = expect_r;
    rx_fill_nxt  = rx_fill_r;
    tx_limit_nxt = tx_limit_r;
    tx_ptr_nxt   = tx_ptr_r;
    rd_rx_nxt    = rd_rx_r;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    res_byte     = ZERO_BYTE;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    unique case (state_r)
      BK_EXEC: begin
        if (q_valid && can_out) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          unique case (q_item.op)
            OP_ADDR_MATCH: begin
              expect_nxt = 1'b1;
            end
            OP_WRITE_BYTE: begin
              if (expect_r) begin
                cmd_nxt     = q_item.data_byte;
                rx_fill_nxt = '0;
                pending_nxt = 1'b1;
              end else if (rx_fill_r < RX_CW'(RX_DEPTH)) begin
                rx_we       = 1'b1;
                rx_fill_nxt = rx_fill_r + RX_CW'(1);
              end
              expect_nxt = 1'b0;
            end
            OP_READ_REQ: begin
              if (tx_ptr_r < tx_limit_r) begin
                tx_re      = 1'b1;
                tx_ptr_nxt = tx_ptr_r + TX_CW'(1);
                rd_rx_nxt  = 1'b0;
                out_load   = 1'b0;
                state_nxt  = BK_READ;
              end
            end
            OP_TX_LOAD: begin
              tx_we = (idx_tx_k < TX_KW'(TX_DEPTH));
            end
            OP_TX_LENGTH: begin
              tx_limit_nxt = (len_k < TL_KW'(TX_DEPTH)) ? len_k[TX_CW-1:0]
                                                        : TX_CW'(TX_DEPTH);
              tx_ptr_nxt   = '0;
            end
            OP_TX_REWIND: begin
              tx_ptr_nxt = '0;
            end
            OP_TAKE_CMD: begin
              res_byte    = cmd_r;
              pending_nxt = 1'b0;
            end
            OP_RX_READ: begin
              if (idx_rx_k < fill_k) begin
                rx_re     = 1'b1;
                rd_rx_nxt = 1'b1;
                out_load  = 1'b0;
                state_nxt = BK_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_READ: begin
        if (can_out) begin
          out_load  = 1'b1;
          res_byte  = rd_rx_r ? rx_rdata : tx_rdata;
          state_nxt = BK_EXEC;
        end
      end
      default: begin
        state_nxt = BK_EXEC;
      end
    endcase
  end

  assign rx_cnt_k = {{CNT_W{1'b0}}, rx_fill_nxt};
  assign tx_cnt_k = {{CNT_W{1'b0}}, tx_ptr_nxt};

  always_comb begin
    out_item_nxt.out_byte        = res_byte;
    out_item_nxt.command_pending = pending_nxt;
    out_item_nxt.rx_count        = rx_cnt_k[CNT_W-1:0];
    out_item_nxt.tx_position     = tx_cnt_k[CNT_W-1:0];
    out_valid_nxt = out_load ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_EXEC;
      cmd_r       <= ZERO_BYTE;
      pending_r   <= 1'b0;
      expect_r    <= 1'b0;
      rx_fill_r   <= '0;
      tx_limit_r  <= '0;
      tx_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      pending_r   <= pending_nxt;
      expect_r    <= expect_nxt;
      rx_fill_r   <= rx_fill_nxt;
      tx_limit_r  <= tx_limit_nxt;
      tx_ptr_r    <= tx_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_rx_r <= rd_rx_nxt;
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  itcm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_we),
    .wr_addr (rx_fill_r[RX_AW-1:0]),
    .wr_data (q_item.data_byte),
    .rd_en   (rx_re),
    .rd_addr (rx_rd_addr),
    .rd_data (rx_rdata)
  );

  itcm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_we),
    .wr_addr (tx_wr_addr),
    .wr_data (q_item.data_byte),
    .rd_en   (tx_re),
    .rd_addr (tx_ptr_r[TX_AW-1:0]),
    .rd_data (tx_rdata)
  );

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

  `ITCM_ASSERT_NOW(a_no_take_in_read, clk, rst_n, state_r == BK_READ, !q_pop, "operation taken during buffer read")
  `ITCM_ASSERT_NOW(a_rx_fill_bound, clk, rst_n, 1'b1, rx_fill_r <= RX_CW'(RX_DEPTH), "receive fill past depth")
  `ITCM_ASSERT_NOW(a_tx_ptr_bound, clk, rst_n, 1'b1, tx_ptr_r <= tx_limit_r, "transmit pointer past length")
  `ITCM_ASSERT_NOW(a_tx_limit_bound, clk, rst_n, 1'b1, tx_limit_r <= TX_CW'(TX_DEPTH), "transmit length past depth")

endmodule

`default_nettype wire
